/* rtl/rmc_sentence_parser_assert.svh */
// assertion macros for the rmc sentence parser checker
`ifndef RMC_SENTENCE_PARSER_ASSERT_SVH
`define RMC_SENTENCE_PARSER_ASSERT_SVH

// check outside reset
`define RMC_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("rmc check failed");

// check that also holds across reset
`define RMC_ASSERT_RST(label, prop) \
    label: assert property (@(posedge i_clk) prop) \
        else $error("rmc reset check failed");

`endif

/* rtl/rmc_pkg.sv */
// shared types, constants and functions of the rmc sentence parser
package rmc_pkg;

    localparam int RMC_QUEUE_DEPTH = 4;
    localparam int RMC_NUM_SLOTS   = 7;
    localparam int RMC_FLAG_SLOTS  = 4;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_A      = 8'h41;
    localparam logic [7:0] CH_N      = 8'h4E;
    localparam logic [7:0] CH_S      = 8'h53;
    localparam logic [7:0] CH_E      = 8'h45;
    localparam logic [7:0] CH_W      = 8'h57;
    localparam logic [7:0] CRC_SEED  = 8'hFF;
    localparam logic [7:0] CRC_POLY  = 8'h8C;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_CRC    = 2'd1;
    localparam logic [1:0] ST_FIELDS = 2'd2;

    localparam logic [3:0] FIELD_COUNT = 4'd11;
    localparam logic [3:0] FIELD_LAST  = 4'd15;
    localparam logic [2:0] HDR_LEN     = 3'd5;

    typedef enum logic [2:0] {
        CLS_DOLLAR = 3'd0,
        CLS_STAR   = 3'd1,
        CLS_COMMA  = 3'd2,
        CLS_DOT    = 3'd3,
        CLS_DIGIT  = 3'd4,
        CLS_OTHER  = 3'd5
    } t_cls;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       buffer_end;
        t_cls       cls;
        logic [3:0] digit;
    } t_token;

    typedef struct packed {
        logic [1:0]  frame_status;
        logic        fix_active;
        logic [1:0]  lat_hemisphere;
        logic [1:0]  lon_hemisphere;
        logic [1:0]  mag_direction;
        logic [29:0] utc_time_milli;
        logic [26:0] latitude_scaled;
        logic [29:0] longitude_scaled;
        logic [16:0] ground_speed_tenths;
        logic [13:0] ground_course_tenths;
        logic [19:0] utc_date;
        logic [13:0] declination_tenths;
    } t_record;

    typedef struct packed {
        logic       hit;
        logic [2:0] idx;
    } t_slot;

    function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic [7:0] hdr_char(input logic [2:0] pos);
        case (pos)
            3'd0:    hdr_char = 8'h47;
            3'd1:    hdr_char = 8'h50;
            3'd2:    hdr_char = 8'h52;
            3'd3:    hdr_char = 8'h4D;
            3'd4:    hdr_char = 8'h43;
            default: hdr_char = 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] hex_lc(input logic [3:0] nib);
        hex_lc = (nib < 4'd10) ? (8'h30 + {4'd0, nib}) : (8'h57 + {4'd0, nib});
    endfunction

    function automatic t_slot num_slot(input logic [3:0] fidx);
        case (fidx)
            4'd1:    num_slot = '{hit: 1'b1, idx: 3'd0};
            4'd3:    num_slot = '{hit: 1'b1, idx: 3'd1};
            4'd5:    num_slot = '{hit: 1'b1, idx: 3'd2};
            4'd7:    num_slot = '{hit: 1'b1, idx: 3'd3};
            4'd8:    num_slot = '{hit: 1'b1, idx: 3'd4};
            4'd9:    num_slot = '{hit: 1'b1, idx: 3'd5};
            4'd10:   num_slot = '{hit: 1'b1, idx: 3'd6};
            default: num_slot = '{hit: 1'b0, idx: 3'd0};
        endcase
    endfunction

    function automatic t_slot flag_slot(input logic [3:0] fidx);
        case (fidx)
            4'd2:    flag_slot = '{hit: 1'b1, idx: 3'd0};
            4'd4:    flag_slot = '{hit: 1'b1, idx: 3'd1};
            4'd6:    flag_slot = '{hit: 1'b1, idx: 3'd2};
            4'd11:   flag_slot = '{hit: 1'b1, idx: 3'd3};
            default: flag_slot = '{hit: 1'b0, idx: 3'd0};
        endcase
    endfunction

    function automatic logic [2:0] num_scale(input logic [2:0] s);
        case (s)
            3'd0:    num_scale = 3'd3;
            3'd1:    num_scale = 3'd4;
            3'd2:    num_scale = 3'd4;
            3'd3:    num_scale = 3'd1;
            3'd4:    num_scale = 3'd1;
            3'd5:    num_scale = 3'd0;
            3'd6:    num_scale = 3'd1;
            default: num_scale = 3'd0;
        endcase
    endfunction

    function automatic logic [29:0] num_max(input logic [2:0] s);
        case (s)
            3'd0:    num_max = 30'd999999999;
            3'd1:    num_max = 30'd99999999;
            3'd2:    num_max = 30'd999999999;
            3'd3:    num_max = 30'd99999;
            3'd4:    num_max = 30'd9999;
            3'd5:    num_max = 30'd999999;
            3'd6:    num_max = 30'd9999;
            default: num_max = 30'd0;
        endcase
    endfunction

    function automatic logic [13:0] pow10(input logic [2:0] k);
        case (k)
            3'd0:    pow10 = 14'd1;
            3'd1:    pow10 = 14'd10;
            3'd2:    pow10 = 14'd100;
            3'd3:    pow10 = 14'd1000;
            3'd4:    pow10 = 14'd10000;
            default: pow10 = 14'd1;
        endcase
    endfunction

endpackage

/* rtl/rmc_fifo.sv */
// small register queue with show-ahead read
module rmc_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_wr,
    input  logic [W-1:0] i_wdata,
    output logic         o_full,
    input  logic         i_rd,
    output logic [W-1:0] o_rdata,
    output logic         o_empty
);
    localparam int AW = $clog2(DEPTH);

    logic [W-1:0] r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;
    logic          wr_go, rd_go;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign wr_go   = i_wr & ~o_full;
    assign rd_go   = i_rd & ~o_empty;
    assign o_rdata = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (wr_go) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_go) begin
                r_wp <= r_wp + 1'b1;
            end
            if (rd_go) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(wr_go) - (AW+1)'(rd_go);
        end
    end
endmodule

/* rtl/rmc_front.sv */
// byte classifier ahead of the token queue
module rmc_front (
    input  logic            [7:0] i_rx_byte,
    input  logic                  i_buffer_end,
    output rmc_pkg::t_token       o_token
);
    import rmc_pkg::*;

    t_cls cls;

    always_comb begin
        if (i_rx_byte == CH_DOLLAR) begin
            cls = CLS_DOLLAR;
        end else if (i_rx_byte == CH_STAR) begin
            cls = CLS_STAR;
        end else if (i_rx_byte == CH_COMMA) begin
            cls = CLS_COMMA;
        end else if (i_rx_byte == CH_DOT) begin
            cls = CLS_DOT;
        end else if (i_rx_byte >= CH_ZERO && i_rx_byte <= CH_NINE) begin
            cls = CLS_DIGIT;
        end else begin
            cls = CLS_OTHER;
        end
    end

    always_comb begin
        o_token.rx_byte    = i_rx_byte;
        o_token.buffer_end = i_buffer_end;
        o_token.cls        = cls;
        o_token.digit      = 4'(i_rx_byte - CH_ZERO);
    end
endmodule

/* rtl/rmc_back.sv */
// sentence state, crc, field decode and record build
module rmc_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  rmc_pkg::t_token  i_token,
    input  logic             i_token_valid,
    output logic             o_token_take,
    output rmc_pkg::t_record o_record,
    output logic             o_record_valid,
    input  logic             i_record_full
);
    import rmc_pkg::*;

    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_HEAD = 4'b0010,
        PH_BODY = 4'b0100,
        PH_CSUM = 4'b1000
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [2:0]  r_hdr, n_hdr;
    logic [3:0]  r_fidx, n_fidx;
    logic [7:0]  r_crc, n_crc;
    logic        r_ccnt, n_ccnt;
    logic [7:0]  r_first, n_first;
    logic [2:0]  r_frac, n_frac;
    logic        r_point, n_point;
    logic        r_started, n_started;
    logic [29:0] r_acc [RMC_NUM_SLOTS];
    logic [29:0] n_acc [RMC_NUM_SLOTS];
    logic [1:0]  r_flag [RMC_FLAG_SLOTS];
    logic [1:0]  n_flag [RMC_FLAG_SLOTS];

    t_slot       ns, fs;
    logic [29:0] acc_cur, acc_max;
    logic [43:0] fin_prod;
    logic [33:0] dig_sum;
    logic [29:0] fin_val, dig_val;
    logic [13:0] fin_pow;
    logic [7:0]  b, crc_upd;
    logic [1:0]  flag_val, st;
    logic        crc_ok;
    t_record     rec;

    assign o_token_take = i_token_valid & ~i_record_full;
    assign b            = i_token.rx_byte;
    assign crc_upd      = crc8_next(r_crc, b);
    assign ns           = num_slot(r_fidx);
    assign fs           = flag_slot(r_fidx);
    assign acc_cur      = r_acc[ns.idx];
    assign acc_max      = num_max(ns.idx);
    assign fin_pow      = pow10(num_scale(ns.idx) - r_frac);
    assign fin_prod     = acc_cur * fin_pow;
    assign fin_val      = (fin_prod > 44'(acc_max)) ? acc_max : fin_prod[29:0];
    assign dig_sum      = {1'b0, acc_cur, 3'b0} + {3'b0, acc_cur, 1'b0} + 34'(i_token.digit);
    assign dig_val      = (dig_sum > 34'(acc_max)) ? acc_max : dig_sum[29:0];
    assign crc_ok       = (r_first == hex_lc(r_crc[7:4])) && (b == hex_lc(r_crc[3:0]));
    assign st           = (r_fidx != FIELD_COUNT) ? ST_FIELDS : (crc_ok ? ST_OK : ST_CRC);

    always_comb begin
        case (fs.idx)
            3'd0:    flag_val = {1'b0, b == CH_A};
            3'd1:    flag_val = (b == CH_N) ? 2'd1 : ((b == CH_S) ? 2'd2 : 2'd0);
            default: flag_val = (b == CH_W) ? 2'd1 : ((b == CH_E) ? 2'd2 : 2'd0);
        endcase
    end

    always_comb begin
        rec = '0;
        rec.frame_status = st;
        if (st == ST_OK) begin
            rec.fix_active           = r_flag[0][0];
            rec.lat_hemisphere       = r_flag[1];
            rec.lon_hemisphere       = r_flag[2];
            rec.mag_direction        = r_flag[3];
            rec.utc_time_milli       = r_acc[0];
            rec.latitude_scaled      = r_acc[1][26:0];
            rec.longitude_scaled     = r_acc[2];
            rec.ground_speed_tenths  = r_acc[3][16:0];
            rec.ground_course_tenths = r_acc[4][13:0];
            rec.utc_date             = r_acc[5][19:0];
            rec.declination_tenths   = r_acc[6][13:0];
        end
    end

    always_comb begin
        n_phase   = r_phase;
        n_hdr     = r_hdr;
        n_fidx    = r_fidx;
        n_crc     = r_crc;
        n_ccnt    = r_ccnt;
        n_first   = r_first;
        n_frac    = r_frac;
        n_point   = r_point;
        n_started = r_started;
        n_acc     = r_acc;
        n_flag    = r_flag;
        o_record  = rec;
        o_record_valid = 1'b0;
        if (o_token_take) begin
            if (i_token.cls == CLS_DOLLAR) begin
                n_phase   = PH_HEAD;
                n_hdr     = '0;
                n_fidx    = '0;
                n_crc     = CRC_SEED;
                n_ccnt    = 1'b0;
                n_first   = '0;
                n_frac    = '0;
                n_point   = 1'b0;
                n_started = 1'b0;
                for (int i = 0; i < RMC_NUM_SLOTS; i++) begin
                    n_acc[i] = '0;
                end
                for (int i = 0; i < RMC_FLAG_SLOTS; i++) begin
                    n_flag[i] = '0;
                end
            end else begin
                case (r_phase)
                    PH_HEAD: begin
                        if (r_hdr < HDR_LEN && b == hdr_char(r_hdr)) begin
                            n_crc = crc_upd;
                            n_hdr = r_hdr + 3'd1;
                            if (r_hdr == HDR_LEN - 3'd1) begin
                                n_phase   = PH_BODY;
                                n_fidx    = '0;
                                n_frac    = '0;
                                n_point   = 1'b0;
                                n_started = 1'b0;
                            end
                        end else begin
                            n_phase = PH_IDLE;
                        end
                    end
                    PH_BODY: begin
                        if (i_token.cls == CLS_STAR || i_token.cls == CLS_COMMA) begin
                            // field end: pad missing fraction digits
                            if (ns.hit) begin
                                n_acc[ns.idx] = fin_val;
                            end
                            n_frac    = '0;
                            n_point   = 1'b0;
                            n_started = 1'b0;
                            if (i_token.cls == CLS_STAR) begin
                                n_phase = PH_CSUM;
                                n_ccnt  = 1'b0;
                            end else begin
                                n_crc = crc_upd;
                                if (r_fidx < FIELD_LAST) begin
                                    n_fidx = r_fidx + 4'd1;
                                end
                            end
                        end else begin
                            n_crc     = crc_upd;
                            n_started = 1'b1;
                            if (fs.hit && !r_started) begin
                                n_flag[fs.idx[1:0]] = flag_val;
                            end
                            if (ns.hit) begin
                                if (i_token.cls == CLS_DIGIT) begin
                                    if (!r_point) begin
                                        n_acc[ns.idx] = dig_val;
                                    end else if (r_frac < num_scale(ns.idx)) begin
                                        n_acc[ns.idx] = dig_val;
                                        n_frac        = r_frac + 3'd1;
                                    end
                                end else if (i_token.cls == CLS_DOT) begin
                                    n_point = 1'b1;
                                end
                            end
                        end
                    end
                    PH_CSUM: begin
                        if (!r_ccnt) begin
                            n_first = b;
                            n_ccnt  = 1'b1;
                        end else begin
                            o_record_valid = 1'b1;
                            n_phase = PH_IDLE;
                            n_ccnt  = 1'b0;
                        end
                    end
                    default: begin
                        n_phase = PH_IDLE;
                    end
                endcase
            end
            if (i_token.buffer_end) begin
                n_phase = PH_IDLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_hdr     <= '0;
            r_fidx    <= '0;
            r_crc     <= CRC_SEED;
            r_ccnt    <= 1'b0;
            r_first   <= '0;
            r_frac    <= '0;
            r_point   <= 1'b0;
            r_started <= 1'b0;
            for (int i = 0; i < RMC_NUM_SLOTS; i++) begin
                r_acc[i] <= '0;
            end
            for (int i = 0; i < RMC_FLAG_SLOTS; i++) begin
                r_flag[i] <= '0;
            end
        end else begin
            r_phase   <= n_phase;
            r_hdr     <= n_hdr;
            r_fidx    <= n_fidx;
            r_crc     <= n_crc;
            r_ccnt    <= n_ccnt;
            r_first   <= n_first;
            r_frac    <= n_frac;
            r_point   <= n_point;
            r_started <= n_started;
            r_acc     <= n_acc;
            r_flag    <= n_flag;
        end
    end
endmodule

/* rtl/rmc_sentence_parser.sv */
// top level of the rmc sentence parser
// record path: token queue, back end, then the record queue, which a pop reads
// throughput: one byte per cycle while the record queue has room
// crc, field decode and decimal accumulate all finish in one back end step
// reset: synchronous active low, empties both queues and returns the parser to idle
module rmc_sentence_parser #(
    parameter int QUEUE_DEPTH = rmc_pkg::RMC_QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_buffer_end,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  o_frame_status,
    output logic        o_fix_active,
    output logic [1:0]  o_lat_hemisphere,
    output logic [1:0]  o_lon_hemisphere,
    output logic [1:0]  o_mag_direction,
    output logic [29:0] o_utc_time_milli,
    output logic [26:0] o_latitude_scaled,
    output logic [29:0] o_longitude_scaled,
    output logic [16:0] o_ground_speed_tenths,
    output logic [13:0] o_ground_course_tenths,
    output logic [19:0] o_utc_date,
    output logic [13:0] o_declination_tenths
);
    import rmc_pkg::*;

    t_token  tok_in, tok_out;
    t_record rec_in, rec_out;
    logic    tok_empty, tok_take, rec_valid, rec_full;

    rmc_front u_front (
        .i_rx_byte    (i_rx_byte),
        .i_buffer_end (i_buffer_end),
        .o_token      (tok_in)
    );

    rmc_fifo #(.W($bits(t_token)), .DEPTH(QUEUE_DEPTH)) u_tok_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (push),
        .i_wdata (tok_in),
        .o_full  (full),
        .i_rd    (tok_take),
        .o_rdata (tok_out),
        .o_empty (tok_empty)
    );

    rmc_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_token        (tok_out),
        .i_token_valid  (~tok_empty),
        .o_token_take   (tok_take),
        .o_record       (rec_in),
        .o_record_valid (rec_valid),
        .i_record_full  (rec_full)
    );

    rmc_fifo #(.W($bits(t_record)), .DEPTH(QUEUE_DEPTH)) u_rec_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (rec_valid),
        .i_wdata (rec_in),
        .o_full  (rec_full),
        .i_rd    (pop),
        .o_rdata (rec_out),
        .o_empty (empty)
    );

    assign o_frame_status         = rec_out.frame_status;
    assign o_fix_active           = rec_out.fix_active;
    assign o_lat_hemisphere       = rec_out.lat_hemisphere;
    assign o_lon_hemisphere       = rec_out.lon_hemisphere;
    assign o_mag_direction        = rec_out.mag_direction;
    assign o_utc_time_milli       = rec_out.utc_time_milli;
    assign o_latitude_scaled      = rec_out.latitude_scaled;
    assign o_longitude_scaled     = rec_out.longitude_scaled;
    assign o_ground_speed_tenths  = rec_out.ground_speed_tenths;
    assign o_ground_course_tenths = rec_out.ground_course_tenths;
    assign o_utc_date             = rec_out.utc_date;
    assign o_declination_tenths   = rec_out.declination_tenths;
endmodule

/* rtl/rmc_checker.sv */
// port checker for the rmc sentence parser and its bind
`include "rmc_sentence_parser_assert.svh"

module rmc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        empty,
    input logic [1:0]  o_frame_status,
    input logic        o_fix_active,
    input logic [1:0]  o_lat_hemisphere,
    input logic [29:0] o_utc_time_milli,
    input logic [26:0] o_latitude_scaled,
    input logic [29:0] o_longitude_scaled,
    input logic [19:0] o_utc_date
);
    import rmc_pkg::*;

    logic fields_zero, fields_in_range;

    assign fields_zero     = (o_fix_active == 1'b0) && (o_lat_hemisphere == 2'd0) &&
                             (o_utc_time_milli == 30'd0) && (o_utc_date == 20'd0);
    assign fields_in_range = (o_utc_time_milli <= 30'd999999999) &&
                             (o_latitude_scaled <= 27'd99999999) &&
                             (o_longitude_scaled <= 30'd999999999) &&
                             (o_utc_date <= 20'd999999);

    `RMC_ASSERT_RST(a_empty_after_reset, !i_rst_n |=> empty)
    `RMC_ASSERT(a_status_code, !empty |-> o_frame_status <= ST_FIELDS)
    `RMC_ASSERT(a_bad_frame_zero, (!empty && o_frame_status != ST_OK) |-> fields_zero)
    `RMC_ASSERT(a_saturation, !empty |-> fields_in_range)
endmodule

bind rmc_sentence_parser rmc_checker u_rmc_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .empty              (empty),
    .o_frame_status     (o_frame_status),
    .o_fix_active       (o_fix_active),
    .o_lat_hemisphere   (o_lat_hemisphere),
    .o_utc_time_milli   (o_utc_time_milli),
    .o_latitude_scaled  (o_latitude_scaled),
    .o_longitude_scaled (o_longitude_scaled),
    .o_utc_date         (o_utc_date)
);
